### design/gde_pkg.sv
// Shared types and constants for the grid diffusion/evaporation block.
package gde_pkg;

   localparam int RATE_W  = 17;
   localparam int LEVEL_W = 32;
   localparam int SUM_W   = 35;
   localparam int OP_W    = 2;

   localparam logic [RATE_W-1:0]  ONE_Q16   = 17'd65536;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL = 32'hFFFF_FFFF;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // register indexes
   localparam logic REG_DIFFUSION   = 1'b0;
   localparam logic REG_EVAPORATION = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRAP,
      ST_READ_WAIT,
      ST_RESP,
      ST_TK_READ,
      ST_TK_DRAIN,
      ST_TK_KEEP,
      ST_TK_FLOW_LO,
      ST_TK_FLOW_HI,
      ST_TK_FLOW,
      ST_TK_MID,
      ST_TK_EVAP,
      ST_TK_WRITE
   } state_type;

endpackage

### design/gde_grid_mem.sv
// Single-write, single-read grid memory with registered read data.
module gde_grid_mem #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/grid_diffuse_evaporate_top.sv
// Top level: toroidal Q16.16 grid with write, read and diffusion/evaporation tick.
//
// One request at a time. A write is accepted in ST_IDLE, done in ST_WRAP and
// answered from ST_RESP; a read also passes ST_READ_WAIT. In ST_WRAP, cell_x and
// cell_y are first wrapped into the grid by subtracting GRID_WIDTH or GRID_HEIGHT,
// one step at a time (never needed for the default 64 x 64 grid). A tick visits
// every cell: each cell needs nine reads through the single read port of the grid
// memory, a drain step, and seven steps through the one shared 32 x 17
// multiplier and its adders (keep share, low and high flow products, flow sum,
// saturate, evaporate, write back). New values go to the second bank of the
// memory; the banks swap at the end of the tick, so no copy pass is needed.
// After reset the block runs a clearing pass over every cell of the active
// bank with req_ready low; CSR writes are taken at any time. Rates above one
// are treated as one. A finished response is held in an output register, so
// the next request can be taken while the previous response still waits on
// rsp_ready.
module grid_diffuse_evaporate_top
   import gde_pkg::*;
#(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [5:0]         req_cell_x,
   input  logic [5:0]         req_cell_y,
   input  logic [LEVEL_W-1:0] req_write_level,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LEVEL_W-1:0] rsp_read_level,
   output logic               rsp_tick_done,
   // register write port
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [RATE_W-1:0]  csr_write_data
);

   localparam int XW     = $clog2(GRID_WIDTH);
   localparam int YW     = $clog2(GRID_HEIGHT);
   localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_W = $clog2(CELLS);
   localparam int ADDR_W = CELL_W + 1;
   // coordinate registers hold the raw 6-bit request value and the grid size
   localparam int CXW = ($clog2(GRID_WIDTH + 1) > 6) ? $clog2(GRID_WIDTH + 1) : 6;
   localparam int CYW = ($clog2(GRID_HEIGHT + 1) > 6) ? $clog2(GRID_HEIGHT + 1) : 6;

   // control state
   state_type           state_ff, state_in;
   logic [CELL_W-1:0]   clr_ff, clr_in;
   logic                bank_ff, bank_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]   diff_ff, diff_in;
   logic [RATE_W-1:0]   evap_ff, evap_in;
   logic                acc_vld_ff, acc_vld_in;

   // payload state
   logic [OP_W-1:0]     op_ff, op_in;
   logic [CXW-1:0]      crd_x_ff, crd_x_in;
   logic [CYW-1:0]      crd_y_ff, crd_y_in;
   logic [LEVEL_W-1:0]  lvl_ff, lvl_in;
   logic [1:0]          kx_ff, kx_in;
   logic [1:0]          ky_ff, ky_in;
   logic                acc_center_ff, acc_center_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [LEVEL_W-1:0]  v_ff, v_in;
   logic [48:0]         prod_ff;
   logic [LEVEL_W-1:0]  keep_ff, keep_in;
   logic [48:0]         lo_ff, lo_in;
   logic [33:0]         flow_ff, flow_in;
   logic [LEVEL_W-1:0]  mid_ff, mid_in;
   logic [LEVEL_W-1:0]  res_level_ff, res_level_in;
   logic                res_done_ff, res_done_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic                rsp_done_ff, rsp_done_in;

   // combinational
   logic                mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]   mem_wr_addr, mem_rd_addr;
   logic [LEVEL_W-1:0]  mem_wr_data, mem_rd_data;
   logic [LEVEL_W-1:0]  mul_a;
   logic [RATE_W-1:0]   mul_b;
   logic [RATE_W-1:0]   diff_eff, evap_eff;
   logic                wrap_x, wrap_y, clr_last, cell_last;
   logic                acc_first;
   logic [XW-1:0]       cur_x, nb_x;
   logic [YW-1:0]       cur_y, nb_y;
   logic [CELL_W-1:0]   cur_cell, nb_cell;
   logic [52:0]         flow_total;
   logic [SUM_W-1:0]    mid_sum;
   logic [LEVEL_W-1:0]  evap_out;

   gde_grid_mem #(
      .ADDR_W (ADDR_W),
      .DATA_W (LEVEL_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // ---- shared helpers ----
   assign diff_eff = (diff_ff > ONE_Q16) ? ONE_Q16 : diff_ff;
   assign evap_eff = (evap_ff > ONE_Q16) ? ONE_Q16 : evap_ff;

   // request coordinates wrap by repeated subtraction, one step per cycle
   assign wrap_x = crd_x_ff >= CXW'(GRID_WIDTH);
   assign wrap_y = crd_y_ff >= CYW'(GRID_HEIGHT);

   assign cur_x = crd_x_ff[XW-1:0];
   assign cur_y = crd_y_ff[YW-1:0];
   assign cur_cell = CELL_W'(cur_y) * CELL_W'(GRID_WIDTH) + CELL_W'(cur_x);
   assign clr_last  = clr_ff == CELL_W'(CELLS - 1);
   assign cell_last = (cur_x == XW'(GRID_WIDTH - 1)) && (cur_y == YW'(GRID_HEIGHT - 1));
   assign acc_first = (kx_ff == 2'd0) && (ky_ff == 2'd0);

   // neighbor column/row for the 3x3 window position (kx, ky), wrapped on the torus
   always_comb begin
      nb_x = cur_x;
      nb_y = cur_y;
      if (kx_ff == 2'd0) begin
         nb_x = (cur_x == '0) ? XW'(GRID_WIDTH - 1) : cur_x - XW'(1);
      end else if (kx_ff == 2'd2) begin
         nb_x = (cur_x == XW'(GRID_WIDTH - 1)) ? '0 : cur_x + XW'(1);
      end
      if (ky_ff == 2'd0) begin
         nb_y = (cur_y == '0) ? YW'(GRID_HEIGHT - 1) : cur_y - YW'(1);
      end else if (ky_ff == 2'd2) begin
         nb_y = (cur_y == YW'(GRID_HEIGHT - 1)) ? '0 : cur_y + YW'(1);
      end
   end
   assign nb_cell = CELL_W'(nb_y) * CELL_W'(GRID_WIDTH) + CELL_W'(nb_x);

   // flow = (S * d) >> 19 with S*d = lo + (hi << 32)
   assign flow_total = 53'({prod_ff[20:0], 32'd0}) + 53'(lo_ff);
   assign mid_sum    = SUM_W'(keep_ff) + SUM_W'(flow_ff);
   assign evap_out   = (prod_ff[48]) ? MAX_LEVEL : prod_ff[47:16];

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:      if (clr_last) state_in = ST_IDLE;
         ST_IDLE:       if (req_valid) state_in = ST_WRAP;
         ST_WRAP: begin
            if (!wrap_x && !wrap_y) begin
               case (op_ff)
                  OP_READ: state_in = ST_READ_WAIT;
                  OP_TICK: state_in = ST_TK_READ;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_READ_WAIT:  state_in = ST_RESP;
         ST_RESP:       if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         ST_TK_READ:    if (kx_ff == 2'd2 && ky_ff == 2'd2) state_in = ST_TK_DRAIN;
         ST_TK_DRAIN:   state_in = ST_TK_KEEP;
         ST_TK_KEEP:    state_in = ST_TK_FLOW_LO;
         ST_TK_FLOW_LO: state_in = ST_TK_FLOW_HI;
         ST_TK_FLOW_HI: state_in = ST_TK_FLOW;
         ST_TK_FLOW:    state_in = ST_TK_MID;
         ST_TK_MID:     state_in = ST_TK_EVAP;
         ST_TK_EVAP:    state_in = ST_TK_WRITE;
         ST_TK_WRITE:   state_in = cell_last ? ST_RESP : ST_TK_READ;
         default:       state_in = ST_IDLE;
      endcase
   end

   // ---- outputs: handshake, memory ports, multiplier operands ----
   always_comb begin
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = {bank_ff, cur_cell};
      mem_wr_data = lvl_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = {bank_ff, cur_cell};
      mul_a       = v_ff;
      mul_b       = ONE_Q16 - diff_eff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = {bank_ff, clr_ff};
            mem_wr_data = '0;
         end
         ST_IDLE: req_ready = 1'b1;
         ST_WRAP: begin
            if (!wrap_x && !wrap_y) begin
               mem_wr_en = op_ff == OP_WRITE;
               mem_rd_en = op_ff == OP_READ;
            end
         end
         ST_TK_READ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = {bank_ff, nb_cell};
         end
         ST_TK_KEEP: begin
            mul_a = v_ff;
            mul_b = ONE_Q16 - diff_eff;
         end
         ST_TK_FLOW_LO: begin
            mul_a = sum_ff[31:0];
            mul_b = diff_eff;
         end
         ST_TK_FLOW_HI: begin
            mul_a = LEVEL_W'(sum_ff[SUM_W-1:32]);
            mul_b = diff_eff;
         end
         ST_TK_EVAP: begin
            mul_a = mid_ff;
            mul_b = evap_eff;
         end
         ST_TK_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = {~bank_ff, cur_cell};
            mem_wr_data = evap_out;
         end
         default: ;
      endcase
   end

   // ---- datapath next values ----
   always_comb begin
      clr_in        = clr_ff;
      bank_in       = bank_ff;
      diff_in       = diff_ff;
      evap_in       = evap_ff;
      op_in         = op_ff;
      crd_x_in      = crd_x_ff;
      crd_y_in      = crd_y_ff;
      lvl_in        = lvl_ff;
      kx_in         = kx_ff;
      ky_in         = ky_ff;
      sum_in        = sum_ff;
      v_in          = v_ff;
      keep_in       = keep_ff;
      lo_in         = lo_ff;
      flow_in       = flow_ff;
      mid_in        = mid_ff;
      res_level_in  = res_level_ff;
      res_done_in   = res_done_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_done_in   = rsp_done_ff;
      acc_vld_in    = state_ff == ST_TK_READ;
      acc_center_in = (kx_ff == 2'd1) && (ky_ff == 2'd1);

      if (csr_write_en) begin
         case (csr_index)
            REG_DIFFUSION:   diff_in = csr_write_data;
            REG_EVAPORATION: evap_in = csr_write_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + CELL_W'(1);
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               crd_x_in = CXW'(req_cell_x);
               crd_y_in = CYW'(req_cell_y);
               lvl_in   = req_write_level;
            end
         end
         ST_WRAP: begin
            if (wrap_x) begin
               crd_x_in = crd_x_ff - CXW'(GRID_WIDTH);
            end else if (wrap_y) begin
               crd_y_in = crd_y_ff - CYW'(GRID_HEIGHT);
            end else begin
               res_level_in = '0;
               res_done_in  = 1'b0;
               if (op_ff == OP_TICK) begin
                  crd_x_in = '0;
                  crd_y_in = '0;
                  kx_in    = '0;
                  ky_in    = '0;
               end
            end
         end
         ST_READ_WAIT: res_level_in = mem_rd_data;
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = res_level_ff;
               rsp_done_in  = res_done_ff;
            end
         end
         ST_TK_READ: begin
            if (acc_first) begin
               sum_in = '0;
            end
            if (kx_ff == 2'd2) begin
               kx_in = '0;
               ky_in = ky_ff + 2'd1;
            end else begin
               kx_in = kx_ff + 2'd1;
            end
         end
         ST_TK_FLOW_LO: keep_in = prod_ff[47:16];
         ST_TK_FLOW_HI: lo_in   = prod_ff;
         ST_TK_FLOW:    flow_in = flow_total[52:19];
         ST_TK_MID:     mid_in  = (mid_sum > SUM_W'(MAX_LEVEL)) ? MAX_LEVEL
                                                               : mid_sum[LEVEL_W-1:0];
         ST_TK_WRITE: begin
            kx_in = '0;
            ky_in = '0;
            if (cell_last) begin
               bank_in     = ~bank_ff;
               res_done_in = 1'b1;
            end else if (cur_x == XW'(GRID_WIDTH - 1)) begin
               crd_x_in = '0;
               crd_y_in = crd_y_ff + CYW'(1);
            end else begin
               crd_x_in = crd_x_ff + CXW'(1);
            end
         end
         default: ;
      endcase

      // window data arrives in the cycle after its read was issued
      if (acc_vld_ff) begin
         if (acc_center_ff) begin
            v_in = mem_rd_data;
         end else begin
            sum_in = sum_ff + SUM_W'(mem_rd_data);
         end
      end
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         diff_ff      <= '0;
         evap_ff      <= ONE_Q16;
         acc_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         diff_ff      <= diff_in;
         evap_ff      <= evap_in;
         acc_vld_ff   <= acc_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      crd_x_ff      <= crd_x_in;
      crd_y_ff      <= crd_y_in;
      lvl_ff        <= lvl_in;
      kx_ff         <= kx_in;
      ky_ff         <= ky_in;
      acc_center_ff <= acc_center_in;
      sum_ff        <= sum_in;
      v_ff          <= v_in;
      prod_ff       <= 49'(mul_a) * 49'(mul_b);
      keep_ff       <= keep_in;
      lo_ff         <= lo_in;
      flow_ff       <= flow_in;
      mid_ff        <= mid_in;
      res_level_ff  <= res_level_in;
      res_done_ff   <= res_done_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_level = rsp_level_ff;
   assign rsp_tick_done  = rsp_done_ff;

`ifndef SYNTHESIS
   // banks swap only when the last cell of a tick is written
   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> ($past(state_ff) == ST_TK_WRITE))
      else $error("grid bank swapped outside tick write-back");

   // grid is written only by clearing, a write request, or tick write-back
   a_mem_write_src: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_WRAP ||
                     state_ff == ST_TK_WRITE))
      else $error("unexpected grid memory write");

   // a tick response never carries a level
   a_tick_level_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_level_ff == '0))
      else $error("tick response with nonzero level");

   // the last window read is still in flight when draining
   a_drain_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TK_DRAIN) |-> acc_vld_ff)
      else $error("window drain without pending read data");
`endif

endmodule
